FILE: rtl/pbrs_pkg.sv
// Shared types, codes and widths for the priority bitmap ready scheduler.
`timescale 1ns / 1ps
package pbrs_pkg;

  localparam int TASK_W = 4;
  localparam int PRIO_W = 5;

  typedef logic [TASK_W-1:0] task_t;
  typedef logic [PRIO_W-1:0] prio_t;

  localparam logic OP_READY  = 1'b0;
  localparam logic OP_SWITCH = 1'b1;

  typedef struct packed {
    logic  op;
    task_t task_id;
    prio_t task_prio;
    logic  keep_running;
  } in_item_t;

  typedef struct packed {
    task_t run_task;
    prio_t run_prio;
    logic  switch_pending;
    logic  task_changed;
    logic  fault;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_A_RD,
    ST_A_WR,
    ST_FIND,
    ST_P_CMP,
    ST_P_LINK,
    ST_DONE
  } state_t;

  typedef struct packed {
    prio_t lvl_addr;
    logic  head_we;
    task_t head_wdata;
    logic  tail_we;
    task_t tail_wdata;
    logic  link_we;
    task_t link_waddr;
    task_t link_wdata;
    task_t link_raddr;
  } qm_req_t;

  typedef struct packed {
    task_t head_rd;
    task_t tail_rd;
    task_t link_rd;
  } qm_rsp_t;

endpackage

FILE: rtl/priority_bitmap_ready_scheduler.sv
// Top level: ready-queue scheduler with level bitmap and queue sequencer.
//
//   channel  ports                           direction  content
//   in       in_valid in_stall in_data       request    op, task_id, task_prio, keep_running
//   out      out_valid out_stall out_data    result     run_task, run_prio, flags
//
// One request at a time; in_stall is high from acceptance until its result is registered.
// Make ready: tail read then link/head/tail write, repeated when it preempts the running task.
// Switch: bitmap search, head read, then link read and head write unless the popped task
// was the last at its level; a re-queue comes first, and no ready task ends the search.
// The queue memories have registered reads.
// Reset clears the bitmap and running task; queue memories need no clearing.
// A stalled result holds the sequencer in its final state; no request is taken meanwhile.
`timescale 1ns / 1ps
module priority_bitmap_ready_scheduler import pbrs_pkg::*; #(
  parameter int NUM_TASKS  = 16,
  parameter int NUM_LEVELS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

  state_t    state_r;
  state_t    state_nxt;
  logic      op_r;
  task_t     task_a_r;
  prio_t     lvl_a_r;
  logic      requeue_r;
  prio_t     lvl_f_r;
  logic      pend_r;
  logic      chg_r;
  logic      flt_r;
  task_t     cur_task_r;
  prio_t     cur_prio_r;
  logic      cur_valid_r;
  logic      cur_run_r;
  logic [NUM_LEVELS-1:0] mask_r;
  logic      out_valid_r;
  out_item_t out_data_r;

  qm_req_t   qreq;
  qm_rsp_t   qrsp;

  logic      accept;
  logic      tid_ok;
  prio_t     prio_sat;
  logic      requeue_now;
  logic      preempt;
  logic      out_free;
  logic      mask_empty;
  logic      pop_last;
  logic [NUM_LEVELS-1:0] low_one;
  prio_t     find_lvl;

  pbrs_queue_mem #(
    .NUM_TASKS  (NUM_TASKS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_qmem (
    .clk (clk),
    .req (qreq),
    .rsp (qrsp)
  );

  assign in_stall    = (state_r != ST_IDLE);
  assign accept      = in_valid && !in_stall;
  assign tid_ok      = (32'(in_data.task_id) < NUM_TASKS);
  assign prio_sat    = (32'(in_data.task_prio) >= NUM_LEVELS) ? PRIO_W'(NUM_LEVELS - 1)
                                                              : in_data.task_prio;
  assign requeue_now = cur_valid_r && cur_run_r && in_data.keep_running;
  assign preempt     = cur_valid_r && cur_run_r && (lvl_a_r < cur_prio_r);
  assign out_free    = !out_valid_r || !out_stall;
  assign mask_empty  = (mask_r == '0);
  assign pop_last    = (qrsp.head_rd == qrsp.tail_rd);
  assign low_one     = mask_r & (~mask_r + NUM_LEVELS'(1));

  always_comb begin
    find_lvl = '0;
    for (int j = 0; j < NUM_LEVELS; j++) begin
      if (low_one[j]) begin
        find_lvl = find_lvl | PRIO_W'(j);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.op == OP_SWITCH) begin
            state_nxt = requeue_now ? ST_A_RD : ST_FIND;
          end else begin
            state_nxt = tid_ok ? ST_A_RD : ST_DONE;
          end
        end
      end
      ST_A_RD: state_nxt = ST_A_WR;
      ST_A_WR: begin
        if (requeue_r) begin
          state_nxt = (op_r == OP_SWITCH) ? ST_FIND : ST_DONE;
        end else begin
          state_nxt = preempt ? ST_A_RD : ST_DONE;
        end
      end
      ST_FIND:   state_nxt = mask_empty ? ST_DONE : ST_P_CMP;
      ST_P_CMP:  state_nxt = pop_last ? ST_DONE : ST_P_LINK;
      ST_P_LINK: state_nxt = ST_DONE;
      ST_DONE:   state_nxt = out_free ? ST_IDLE : ST_DONE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    qreq            = '0;
    qreq.lvl_addr   = lvl_a_r;
    qreq.head_wdata = task_a_r;
    qreq.tail_wdata = task_a_r;
    qreq.link_waddr = qrsp.tail_rd;
    qreq.link_wdata = task_a_r;
    qreq.link_raddr = qrsp.head_rd;
    unique case (state_r)
      ST_A_WR: begin
        qreq.tail_we = 1'b1;
        if (mask_r[LW'(lvl_a_r)]) begin
          qreq.link_we = 1'b1;
        end else begin
          qreq.head_we = 1'b1;
        end
      end
      ST_FIND: qreq.lvl_addr = find_lvl;
      ST_P_LINK: begin
        qreq.lvl_addr   = lvl_f_r;
        qreq.head_we    = 1'b1;
        qreq.head_wdata = qrsp.link_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mask_r      <= '0;
      cur_task_r  <= '0;
      cur_prio_r  <= '0;
      cur_valid_r <= 1'b0;
      cur_run_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept && in_data.op == OP_SWITCH && requeue_now) begin
            cur_run_r <= 1'b0;
          end
        end
        ST_A_WR: begin
          mask_r[LW'(lvl_a_r)] <= 1'b1;
          if (!requeue_r && preempt) begin
            cur_run_r <= 1'b0;
          end
        end
        ST_P_CMP: begin
          cur_task_r  <= qrsp.head_rd;
          cur_prio_r  <= lvl_f_r;
          cur_valid_r <= 1'b1;
          cur_run_r   <= 1'b1;
          if (pop_last) begin
            mask_r[LW'(lvl_f_r)] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_r   <= in_data.op;
          pend_r <= 1'b0;
          chg_r  <= 1'b0;
          flt_r  <= 1'b0;
          if (in_data.op == OP_SWITCH && requeue_now) begin
            task_a_r  <= cur_task_r;
            lvl_a_r   <= cur_prio_r;
            requeue_r <= 1'b1;
          end else begin
            task_a_r  <= in_data.task_id;
            lvl_a_r   <= prio_sat;
            requeue_r <= 1'b0;
          end
        end
      end
      ST_A_WR: begin
        if (!requeue_r && preempt) begin
          task_a_r  <= cur_task_r;
          lvl_a_r   <= cur_prio_r;
          requeue_r <= 1'b1;
          pend_r    <= 1'b1;
        end
      end
      ST_FIND: begin
        if (mask_empty) begin
          flt_r <= 1'b1;
        end
        lvl_f_r <= find_lvl;
      end
      ST_P_CMP: begin
        chg_r <= !cur_valid_r || (qrsp.head_rd != cur_task_r);
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_r.run_task       <= cur_task_r;
          out_data_r.run_prio       <= cur_prio_r;
          out_data_r.switch_pending <= pend_r;
          out_data_r.task_changed   <= chg_r;
          out_data_r.fault          <= flt_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_run_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cur_run_r |-> cur_valid_r)
    else $error("running flag set without a valid task");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.fault && out_data_r.task_changed) &&
                    !(out_data_r.switch_pending &&
                      (out_data_r.fault || out_data_r.task_changed)))
    else $error("conflicting result flags");

  a_last_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_P_CMP && pop_last) |=> !mask_r[LW'($past(lvl_f_r))])
    else $error("level bit kept after popping its last task");

  a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not registered on completion");
`endif

endmodule

FILE: rtl/pbrs_queue_mem.sv
// Queue storage: per-level head and tail memories and the per-task link memory.
`timescale 1ns / 1ps
module pbrs_queue_mem import pbrs_pkg::*; #(
  parameter int NUM_TASKS  = 16,
  parameter int NUM_LEVELS = 32
) (
  input  logic    clk,
  input  qm_req_t req,
  output qm_rsp_t rsp
);

  localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

  task_t   link_mem [NUM_TASKS];
  task_t   head_mem [NUM_LEVELS];
  task_t   tail_mem [NUM_LEVELS];
  qm_rsp_t rsp_r;

  logic [LW-1:0] lvl_idx;
  logic [TW-1:0] link_widx;
  logic [TW-1:0] link_ridx;

  assign lvl_idx   = LW'(req.lvl_addr);
  assign link_widx = TW'(req.link_waddr);
  assign link_ridx = TW'(req.link_raddr);

  always_ff @(posedge clk) begin
    if (req.head_we) begin
      head_mem[lvl_idx] <= req.head_wdata;
    end
    if (req.tail_we) begin
      tail_mem[lvl_idx] <= req.tail_wdata;
    end
    if (req.link_we) begin
      link_mem[link_widx] <= req.link_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rsp_r.head_rd <= head_mem[lvl_idx];
    rsp_r.tail_rd <= tail_mem[lvl_idx];
    rsp_r.link_rd <= link_mem[link_ridx];
  end

  assign rsp = rsp_r;

endmodule
